// ===== hw/rtl/ngst_pkg.sv =====
`default_nettype none

package ngst_pkg;

    localparam int POS_W       = 24;
    localparam int THR_W       = 24;
    localparam int IDX_W       = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int DEF_MAX_GUIDES = 64;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_SNAP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        t_cmd                     command;
        logic                     vertical;
        logic signed [POS_W-1:0]  position;
        logic [IDX_W-1:0]         index;
        logic [THR_W-1:0]         threshold;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [POS_W-1:0]  snapped;
        logic [CNT_OUT_W-1:0]     count;
    } t_out_item;

    typedef struct packed {
        logic                     vertical;
        logic [POS_W-1:0]         position;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic walk;
        logic finish;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_walk;
        logic walk_busy;
        logic out_free;
    } t_ctrl_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/ngst_if.sv =====
`default_nettype none

interface ngst_in_if;
    logic               valid;
    logic               ready;
    ngst_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ngst_out_if;
    logic                valid;
    logic                ready;
    ngst_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nearest_guide_snap_table_core.sv =====
// Ordered table of up to MAX_GUIDES guide lines (orientation bit plus signed Q15.8
// position) with add, remove, clear and nearest-guide snap. One command is in work at
// a time; the result sits in an output register, so the next command is taken while
// it waits. Add, clear and a rejected remove go from acceptance straight to the
// finish step. Snap and a valid remove first walk the table, a snap from entry 0
// and a remove at index k from entry k + 1, moving each later entry down by one:
// both walk one entry per cycle through the single read port of the guide RAM.
// The RAM is not cleared after reset; only entries below the count are ever read.
`default_nettype none

module nearest_guide_snap_table_core #(
    parameter int MAX_GUIDES = ngst_pkg::DEF_MAX_GUIDES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ngst_in_if.sink     i_in,
    ngst_out_if.source  o_out
);

    ngst_pkg::t_ctrl_cmd ctrl_cmd;
    ngst_pkg::t_ctrl_sts ctrl_sts;
    logic                in_ready;

    ngst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (ctrl_sts),
        .o_cmd      (ctrl_cmd)
    );

    ngst_datapath #(
        .MAX_GUIDES (MAX_GUIDES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_in.data),
        .i_cmd       (ctrl_cmd),
        .o_sts       (ctrl_sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    assign i_in.ready = in_ready;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.capture |=> !in_ready)
        else $error("transaction accepted while another is in work");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl_cmd.capture && (ctrl_cmd.finish || ctrl_cmd.walk)))
        else $error("capture overlaps walk or finish");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.finish |=> o_out.valid)
        else $error("finished command did not present a result");

    a_walk_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_cmd.walk && !ctrl_sts.walk_busy) |=> !ctrl_cmd.walk)
        else $error("walk did not end after the table was exhausted");

endmodule

`default_nettype wire

// ===== hw/rtl/ngst_ram.sv =====
`default_nettype none

module ngst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/ngst_ctrl.sv =====
`default_nettype none

module ngst_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ngst_pkg::t_ctrl_sts i_sts,
    output ngst_pkg::t_ctrl_cmd      o_cmd
);

    ngst_pkg::t_state r_state;
    ngst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ngst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ngst_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.need_walk ? ngst_pkg::S_WALK : ngst_pkg::S_FIN;
                end
            end
            ngst_pkg::S_WALK: begin
                if (!i_sts.walk_busy) begin
                    n_state = ngst_pkg::S_FIN;
                end
            end
            ngst_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ngst_pkg::S_IDLE;
                end
            end
            default: n_state = ngst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.walk    = 1'b0;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            ngst_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ngst_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            ngst_pkg::S_FIN: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ngst_datapath.sv =====
`default_nettype none

module ngst_datapath #(
    parameter int MAX_GUIDES = ngst_pkg::DEF_MAX_GUIDES,
    localparam int AW = (MAX_GUIDES > 1) ? $clog2(MAX_GUIDES) : 1,
    localparam int CW = $clog2(MAX_GUIDES + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ngst_pkg::t_in_item  i_data,
    input  wire ngst_pkg::t_ctrl_cmd i_cmd,
    output ngst_pkg::t_ctrl_sts      o_sts,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ngst_pkg::t_out_item      o_out_data
);

    localparam int XW = ((CW > ngst_pkg::IDX_W) ? CW : ngst_pkg::IDX_W) + 1;
    localparam int EW = $bits(ngst_pkg::t_entry);

    ngst_pkg::t_cmd                    r_cmd;
    logic                              r_vert;
    logic [ngst_pkg::POS_W-1:0]        r_pos;
    ngst_pkg::t_status                 r_status, n_status;
    logic [CW-1:0]                     r_count, n_count;
    logic [CW-1:0]                     r_ptr, n_ptr;
    logic                              r_dvld, n_dvld;
    logic [CW-1:0]                     r_daddr, n_daddr;
    logic [ngst_pkg::POS_W-1:0]        r_best, n_best;
    logic [ngst_pkg::THR_W-1:0]        r_best_dist, n_best_dist;
    logic                              r_out_valid, n_out_valid;
    ngst_pkg::t_out_item               r_out, n_out;

    logic                              bad_idx;
    logic                              is_full;
    logic [XW-1:0]                     idx_x;
    logic                              walk_more;
    logic                              ram_we, ram_re;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [EW-1:0]                     ram_wdata, ram_rdata;
    ngst_pkg::t_entry                  rd_entry, wr_entry;
    logic [CW-1:0]                     daddr_dec;
    logic signed [ngst_pkg::POS_W:0]   diff;
    logic [ngst_pkg::POS_W:0]          mag;
    logic [ngst_pkg::THR_W-1:0]        guide_dist;

    ngst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_GUIDES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_x     = XW'(i_data.index);
    assign bad_idx   = idx_x >= XW'(r_count);
    assign is_full   = r_count == CW'(MAX_GUIDES);
    assign walk_more = r_ptr < r_count;
    assign rd_entry  = ngst_pkg::t_entry'(ram_rdata);
    assign daddr_dec = r_daddr - CW'(1);

    assign diff = $signed({rd_entry.position[ngst_pkg::POS_W-1], rd_entry.position})
                - $signed({r_pos[ngst_pkg::POS_W-1], r_pos});
    assign mag  = diff[ngst_pkg::POS_W] ? (ngst_pkg::POS_W + 1)'(-diff)
                                        : (ngst_pkg::POS_W + 1)'(diff);
    assign guide_dist = mag[ngst_pkg::THR_W-1:0];

    assign o_sts.need_walk = (i_data.command == ngst_pkg::CMD_SNAP)
                          || ((i_data.command == ngst_pkg::CMD_REMOVE) && !bad_idx);
    assign o_sts.walk_busy = walk_more || r_dvld;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_status    = r_status;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_dvld      = 1'b0;
        n_daddr     = r_daddr;
        n_best      = r_best;
        n_best_dist = r_best_dist;
        n_out       = r_out;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        wr_entry    = '{vertical: r_vert, position: r_pos};
        ram_re      = 1'b0;
        ram_raddr   = r_ptr[AW-1:0];

        if (i_cmd.capture) begin
            n_best      = i_data.position;
            n_best_dist = i_data.threshold;
            n_status    = ngst_pkg::ST_OK;
            n_ptr       = '0;
            unique case (i_data.command)
                ngst_pkg::CMD_ADD: begin
                    if (is_full) begin
                        n_status = ngst_pkg::ST_FULL;
                    end
                end
                ngst_pkg::CMD_REMOVE: begin
                    if (bad_idx) begin
                        n_status = ngst_pkg::ST_BAD_INDEX;
                    end else begin
                        n_ptr = CW'(idx_x + XW'(1));
                    end
                end
                ngst_pkg::CMD_CLEAR, ngst_pkg::CMD_SNAP: begin
                    n_ptr = '0;
                end
                default: n_ptr = '0;
            endcase
        end

        if (i_cmd.walk) begin
            if (walk_more) begin
                ram_re  = 1'b1;
                n_ptr   = r_ptr + CW'(1);
                n_dvld  = 1'b1;
                n_daddr = r_ptr;
            end
            if (r_dvld) begin
                if (r_cmd == ngst_pkg::CMD_REMOVE) begin
                    ram_we    = 1'b1;
                    ram_waddr = daddr_dec[AW-1:0];
                    wr_entry  = rd_entry;
                end else if ((rd_entry.vertical == r_vert) && (guide_dist < r_best_dist)) begin
                    n_best_dist = guide_dist;
                    n_best      = rd_entry.position;
                end
            end
        end

        if (i_cmd.finish) begin
            if (r_status == ngst_pkg::ST_OK) begin
                unique case (r_cmd)
                    ngst_pkg::CMD_ADD: begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    ngst_pkg::CMD_REMOVE: n_count = r_count - CW'(1);
                    ngst_pkg::CMD_CLEAR:  n_count = '0;
                    ngst_pkg::CMD_SNAP:   n_count = r_count;
                    default:              n_count = r_count;
                endcase
            end
            n_out.status  = r_status;
            n_out.snapped = (r_cmd == ngst_pkg::CMD_SNAP) ? r_best : '0;
            n_out.count   = ngst_pkg::CNT_OUT_W'(n_count);
            n_out_valid   = 1'b1;
        end
        ram_wdata = EW'(wr_entry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dvld      <= n_dvld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_data.command;
            r_vert <= i_data.vertical;
            r_pos  <= i_data.position;
        end
        r_status    <= n_status;
        r_ptr       <= n_ptr;
        r_daddr     <= n_daddr;
        r_best      <= n_best;
        r_best_dist <= n_best_dist;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== test/nearest_guide_snap_table_core_test.sv =====
`timescale 1ns / 1ps

module nearest_guide_snap_table_core_test;
    import ngst_pkg::*;

    localparam int MAX_GUIDES   = DEF_MAX_GUIDES;
    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} t_mix;

    class guide_scoreboard;
        t_entry    guides[MAX_GUIDES];
        int        guide_count;
        t_out_item answers_due[$];
        int        failures;

        function void note_failure(string msg);
            if (failures < REPORT_LIMIT) begin
                $display("[%0t] %s", $time, msg);
            end
            failures++;
        endfunction

        function void apply_command(t_in_item cmd);
            t_out_item         ans;
            int                query;
            int                guide_dist;
            int                best_dist;
            logic [POS_W-1:0]  best;
            ans = '0;
            ans.status = ST_OK;
            case (cmd.command)
                CMD_ADD: begin
                    if (guide_count >= MAX_GUIDES) begin
                        ans.status = ST_FULL;
                    end else begin
                        guides[guide_count].vertical = cmd.vertical;
                        guides[guide_count].position = cmd.position;
                        guide_count++;
                    end
                end
                CMD_REMOVE: begin
                    if (int'(cmd.index) >= guide_count) begin
                        ans.status = ST_BAD_INDEX;
                    end else begin
                        for (int i = cmd.index; i + 1 < guide_count; i++) begin
                            guides[i] = guides[i + 1];
                        end
                        guide_count--;
                    end
                end
                CMD_CLEAR: begin
                    guide_count = 0;
                end
                default: begin
                    query     = $signed(cmd.position);
                    best      = cmd.position;
                    best_dist = int'(cmd.threshold);
                    for (int i = 0; i < guide_count; i++) begin
                        if (guides[i].vertical == cmd.vertical) begin
                            guide_dist = int'($signed(guides[i].position)) - query;
                            if (guide_dist < 0) begin
                                guide_dist = -guide_dist;
                            end
                            if (guide_dist < best_dist) begin
                                best_dist = guide_dist;
                                best      = guides[i].position;
                            end
                        end
                    end
                    ans.snapped = best;
                end
            endcase
            ans.count = 7'(guide_count);
            answers_due.push_back(ans);
        endfunction

        function void check_answer(t_out_item got);
            t_out_item exp;
            if (answers_due.size() == 0) begin
                note_failure($sformatf("unexpected result: status=%0d snapped=%h count=%0d",
                                       got.status, got.snapped, got.count));
                return;
            end
            exp = answers_due.pop_front();
            if (got.status !== exp.status || got.snapped !== exp.snapped ||
                got.count !== exp.count) begin
                note_failure($sformatf({"mismatch: expected status=%0d snapped=%h count=%0d,",
                                        " got status=%0d snapped=%h count=%0d"},
                                       exp.status, exp.snapped, exp.count,
                                       got.status, got.snapped, got.count));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ngst_in_if  cmd_if ();
    ngst_out_if ans_if ();

    nearest_guide_snap_table_core #(
        .MAX_GUIDES(MAX_GUIDES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (ans_if)
    );

    guide_scoreboard guide_sb;
    t_idle_mode      idle_mode = IDLE_NONE;
    int              quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SENDER: return chance(84);
            IDLE_BOTH:   return chance(7);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return chance(84);
            IDLE_BOTH:     return chance(7);
            default:       return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        ans_if.ready <= !receiver_stalls();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ans_if.valid && ans_if.ready) begin
            guide_sb.check_answer(ans_if.data);
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (ans_if.valid && ans_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_command(input t_in_item item);
        while (sender_waits()) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= item;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        guide_sb.apply_command(item);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input t_cmd c, input logic v, input logic [POS_W-1:0] p,
                               input logic [IDX_W-1:0] x, input logic [THR_W-1:0] t);
        t_in_item item;
        item.command   = c;
        item.vertical  = v;
        item.position  = p;
        item.index     = x;
        item.threshold = t;
        send_command(item);
    endtask

    function automatic t_in_item random_command(t_mix mix);
        t_in_item item;
        int       r;
        int       k;
        int       off;
        item.vertical  = $urandom_range(1);
        item.position  = POS_W'($urandom);
        item.index     = IDX_W'($urandom);
        item.threshold = THR_W'($urandom);
        r = $urandom_range(99);
        case (mix)
            MIX_GROW:     item.command = r < 65 ? CMD_ADD : r < 75 ? CMD_REMOVE :
                                         r < 99 ? CMD_SNAP : CMD_CLEAR;
            MIX_BALANCED: item.command = r < 35 ? CMD_ADD : r < 60 ? CMD_REMOVE :
                                         r < 96 ? CMD_SNAP : CMD_CLEAR;
            default:      item.command = r < 15 ? CMD_ADD : r < 60 ? CMD_REMOVE :
                                         r < 95 ? CMD_SNAP : CMD_CLEAR;
        endcase
        case (item.command)
            CMD_ADD: begin
                if (guide_sb.guide_count > 0 && chance(10)) begin
                    k = $urandom_range(guide_sb.guide_count - 1);
                    item.position = guide_sb.guides[k].position;
                end else if (chance(50)) begin
                    item.position = POS_W'(int'($urandom_range(16384)) - 8192);
                end
            end
            CMD_REMOVE: begin
                if (guide_sb.guide_count > 0 && chance(80)) begin
                    item.index = IDX_W'($urandom_range(guide_sb.guide_count - 1));
                end
            end
            CMD_SNAP: begin
                // query close to a held guide so the nearest search has real contenders
                if (guide_sb.guide_count > 0 && chance(75)) begin
                    k   = $urandom_range(guide_sb.guide_count - 1);
                    off = int'($urandom_range(4096)) - 2048;
                    item.position = guide_sb.guides[k].position + POS_W'(off);
                    if (chance(80)) begin
                        item.vertical = guide_sb.guides[k].vertical;
                    end
                    if (chance(15)) begin
                        item.threshold = THR_W'(off < 0 ? -off : off);
                    end else begin
                        item.threshold = THR_W'($urandom_range(4096));
                    end
                end
            end
            default: ;
        endcase
        return item;
    endfunction

    initial begin
        t_mix mix;
        int   episode_left;
        int   r;
        guide_sb      = new();
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        ans_if.ready  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table
        send_fields(CMD_SNAP,   1'b1, 24'h000500, 6'd0,  24'hFFFFFF);
        send_fields(CMD_REMOVE, 1'b0, 24'h000000, 6'd0,  24'h000000);
        send_fields(CMD_REMOVE, 1'b1, 24'hFFFFFF, 6'd63, 24'hFFFFFF);
        // position extremes, maximum distance equals maximum threshold
        send_fields(CMD_ADD,    1'b1, 24'h7FFFFF, 6'd0,  24'h000000);
        send_fields(CMD_ADD,    1'b0, 24'h800000, 6'd0,  24'h000000);
        send_fields(CMD_SNAP,   1'b1, 24'h800000, 6'd0,  24'hFFFFFF);
        send_fields(CMD_SNAP,   1'b0, 24'h7FFFFF, 6'd0,  24'hFFFFFF);
        send_fields(CMD_SNAP,   1'b1, 24'h7FFFFF, 6'd0,  24'h000000);
        send_fields(CMD_SNAP,   1'b1, 24'h7FFFFE, 6'd0,  24'h000002);
        // tie goes to the earliest entry
        send_fields(CMD_ADD,    1'b1, 24'h000100, 6'd0,  24'h000000);
        send_fields(CMD_ADD,    1'b1, 24'h000300, 6'd0,  24'h000000);
        send_fields(CMD_SNAP,   1'b1, 24'h000200, 6'd0,  24'h000400);
        send_fields(CMD_SNAP,   1'b0, 24'h000200, 6'd0,  24'hFFFFFF);
        send_fields(CMD_ADD,    1'b0, 24'hFFFF00, 6'd0,  24'h000000);
        // remove middle, remove last, index equal to count
        send_fields(CMD_REMOVE, 1'b0, 24'h000000, 6'd1,  24'h000000);
        send_fields(CMD_SNAP,   1'b0, 24'h000000, 6'd0,  24'h000101);
        send_fields(CMD_REMOVE, 1'b0, 24'h000000, 6'd3,  24'h000000);
        send_fields(CMD_REMOVE, 1'b0, 24'h000000, 6'd3,  24'h000000);
        send_fields(CMD_CLEAR,  1'b0, 24'h000000, 6'd0,  24'h000000);
        send_fields(CMD_SNAP,   1'b1, 24'h000100, 6'd0,  24'hFFFFFF);
        send_fields(CMD_ADD,    1'b0, 24'h000000, 6'd0,  24'h000000);
        send_fields(CMD_SNAP,   1'b0, 24'h000000, 6'd0,  24'h000001);

        mix          = MIX_GROW;
        episode_left = $urandom_range(60, 120);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                idle_mode = t_idle_mode'((n / 150) % 4);
            end
            if (episode_left == 0) begin
                r            = $urandom_range(99);
                mix          = r < 40 ? MIX_GROW : r < 75 ? MIX_BALANCED : MIX_SHRINK;
                episode_left = $urandom_range(30, 120);
            end
            episode_left--;
            send_command(random_command(mix));
        end
        cmd_if.valid <= 1'b0;
        idle_mode = IDLE_NONE;

        while (guide_sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (guide_sb.failures == 0 && guide_sb.answers_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
